FILE: hdl/ptg_pkg.sv
`default_nettype none
package ptg_pkg;

    localparam int JOINTS_DEF    = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W         = 256;
    localparam int NUM_W         = 72;
    localparam int QCLAMP        = 100;
    localparam int QUO_W         = QCLAMP + 1;
    localparam int LIMBS         = ACC_W / 32;
    localparam logic [QUO_W-1:0] Q_LIM = {1'b1, {QCLAMP{1'b0}}};

    localparam logic CMD_PLAN     = 1'b0;
    localparam logic CMD_EVAL     = 1'b1;
    localparam logic MODE_CUBIC   = 1'b0;
    localparam logic MODE_QUARTIC = 1'b1;

    localparam logic [1:0] CH_QUARTIC = 2'd0;
    localparam logic [1:0] CH_CUBIC   = 2'd1;
    localparam logic [1:0] CH_SQUARE  = 2'd2;

    localparam logic [1:0] PL_POS = 2'd0;
    localparam logic [1:0] PL_VEL = 2'd1;
    localparam logic [1:0] PL_ACC = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic        [2:0]  joint;
        logic               mode;
        logic signed [31:0] start_pos;
        logic signed [31:0] start_vel;
        logic signed [31:0] end_pos;
        logic signed [31:0] via_pos;
        logic        [31:0] duration;
        logic        [31:0] eval_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic               zero_duration_error;
    } t_out;

    typedef struct packed {
        logic signed [63:0] quartic;
        logic signed [63:0] cubic;
        logic signed [63:0] square;
        logic signed [31:0] linear;
        logic signed [31:0] constant;
    } t_coef;

    typedef struct packed {
        logic signed [3:0] kd;
        logic signed [6:0] k0;
        logic signed [6:0] k1;
        logic signed [6:0] ka;
    } t_wts;

    typedef enum logic [3:0] {
        S_IDLE, S_DV, S_DSTART, S_DWAIT, S_WRITE, S_RD, S_TERM, S_MUL, S_FIN, S_DONE
    } t_state;

    // numerator weights: dv, x0, x1, via
    function automatic t_wts ptg_wts(input logic mode, input logic [1:0] chain);
        t_wts w;
        w = '{kd: 4'sd0, k0: 7'sd0, k1: 7'sd0, ka: 7'sd0};
        if (mode == MODE_QUARTIC) begin
            case (chain)
                CH_QUARTIC: w = '{kd: -4'sd2, k0: -7'sd8,  k1: -7'sd8, ka: 7'sd16};
                CH_CUBIC:   w = '{kd: 4'sd5,  k0: 7'sd18,  k1: 7'sd14, ka: -7'sd32};
                default:    w = '{kd: -4'sd4, k0: -7'sd11, k1: -7'sd5, ka: 7'sd16};
            endcase
        end else begin
            case (chain)
                CH_CUBIC:   w = '{kd: 4'sd1,  k0: 7'sd2,  k1: -7'sd2, ka: 7'sd0};
                default:    w = '{kd: -4'sd2, k0: -7'sd3, k1: 7'sd3,  ka: 7'sd0};
            endcase
        end
        return w;
    endfunction

    function automatic logic [3:0] ptg_term_mul(input logic [1:0] pl, input logic [2:0] idx);
        logic [3:0] m;
        m = 4'd1;
        case (pl)
            PL_VEL: begin
                case (idx)
                    3'd0:    m = 4'd4;
                    3'd1:    m = 4'd3;
                    3'd2:    m = 4'd2;
                    default: m = 4'd1;
                endcase
            end
            PL_ACC: begin
                case (idx)
                    3'd0:    m = 4'd12;
                    3'd1:    m = 4'd6;
                    default: m = 4'd2;
                endcase
            end
            default: m = 4'd1;
        endcase
        return m;
    endfunction

    // shift in units of FRAC_BITS
    function automatic logic [2:0] ptg_term_shk(input logic [2:0] idx);
        logic [2:0] k;
        case (idx)
            3'd0:    k = 3'd0;
            3'd1:    k = 3'd1;
            3'd2:    k = 3'd2;
            3'd3:    k = 3'd4;
            default: k = 3'd5;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ptg_div.sv
`default_nettype none
module ptg_div import ptg_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic        [2:0]       i_steps,
    input  wire logic        [31:0]      i_den,
    output logic                         o_done,
    output logic             [63:0]      o_coef
);
    localparam int DW = QUO_W + FRAC_BITS;
    localparam int CW = $clog2(DW);

    logic             r_busy, r_done, r_neg;
    logic [2:0]       r_steps;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_sr;
    logic [31:0]      r_rem;
    logic [QUO_W-1:0] r_q;

    logic [NUM_W-1:0] mag;
    logic [32:0]      r2, rsub;
    logic             ge;
    logic [31:0]      n_rem;
    logic [DW-1:0]    quo;
    logic [QUO_W-1:0] qc;
    logic             ovp, ovn;

    always_comb begin
        mag   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        r2    = {r_rem, r_sr[DW-1]};
        ge    = r2 >= {1'b0, i_den};
        rsub  = r2 - {1'b0, i_den};
        n_rem = ge ? rsub[31:0] : r2[31:0];
        quo   = {r_sr[DW-2:0], ge};
        qc    = (|quo[DW-1:QCLAMP]) ? Q_LIM : quo[QUO_W-1:0];
        ovp   = |r_q[QUO_W-1:63];
        ovn   = (|r_q[QUO_W-1:64]) || (r_q[63] && (|r_q[62:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_neg   <= i_num[NUM_W-1];
                r_steps <= i_steps;
                r_sr    <= {QUO_W'(mag), {FRAC_BITS{1'b0}}};
                r_rem   <= '0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                if (r_cnt == CW'(DW - 1)) begin
                    r_q   <= qc;
                    r_cnt <= '0;
                    r_rem <= '0;
                    if (r_steps == 3'd1) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_steps <= r_steps - 3'd1;
                        r_sr    <= {qc, {FRAC_BITS{1'b0}}};
                    end
                end else begin
                    r_sr  <= quo;
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_coef = r_neg ? (ovn ? 64'h8000_0000_0000_0000 : -r_q[63:0])
                          : (ovp ? 64'h7FFF_FFFF_FFFF_FFFF : r_q[63:0]);
endmodule
`default_nettype wire

FILE: hdl/polynomial_trajectory_generator_core.sv
`default_nettype none
// Per-joint polynomial trajectory unit. A plan transaction computes the five
// coefficients of p(t) and writes them to the joint's entry of the coefficient
// memory; an evaluate transaction returns position, velocity and acceleration at
// eval_time. One transaction is processed at a time. A plan runs the bit-serial
// divider for 9 steps in 3 chains for a quartic and 5 steps in 2 chains for a
// cubic. An evaluate does 12 term adds and 9 Horner passes over 8 limbs each
// through one shared 32x32 multiplier, plus the table read, one finish per
// output and the load. Zero duration or an out-of-range joint goes straight to
// the load. The result waits in an output register; a new transaction is taken
// while it waits.
module polynomial_trajectory_generator_core import ptg_pkg::*; #(
    parameter int JOINTS    = JOINTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);
    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    t_state r_state, n_state;
    t_in    r_in;
    t_coef  r_mem [JOINTS];
    logic [JOINTS-1:0] r_vld;
    t_coef  r_rd;
    logic   r_rd_vld;

    logic signed [64:0] r_dv;
    logic [1:0]         r_chain;
    logic signed [63:0] r_q4, r_q3, r_q2;

    logic [1:0]             r_p;
    logic [2:0]             r_i;
    logic [2:0]             r_limb;
    logic [31:0]            r_carry;
    logic [ACC_W-1:0]       r_acc;
    logic signed [31:0]     r_res [3];
    logic                   r_err;
    logic                   r_out_valid;
    t_out                   r_out;

    logic [JW-1:0] addr;
    logic          in_acc, oor_in, oor;
    logic          div_done;
    logic [63:0]   div_coef;
    logic signed [NUM_W-1:0] num;
    t_wts          w;
    t_coef         ent;
    logic signed [63:0]      pat;
    logic signed [68:0]      tm;
    logic signed [ACC_W-1:0] te, tsh, sh;
    logic [7:0]    shamt, samt;
    logic [63:0]   prod;
    logic signed [31:0] satv;
    logic          out_load;

    assign addr   = JW'(r_in.joint);
    assign in_acc = i_in_valid && o_in_ready;
    assign oor_in = {29'd0, i_in.joint} >= 32'(JOINTS);
    assign oor    = {29'd0, r_in.joint} >= 32'(JOINTS);
    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        w   = ptg_wts(r_in.mode, r_chain);
        num = w.kd * r_dv
            + ((w.k0 * r_in.start_pos + w.k1 * r_in.end_pos + w.ka * r_in.via_pos)
               <<< FRAC_BITS);
    end

    ptg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_num   (num),
        .i_steps (3'(3'd4 - {1'b0, r_chain})),
        .i_den   (r_in.duration),
        .o_done  (div_done),
        .o_coef  (div_coef)
    );

    always_comb begin
        ent = r_rd_vld ? r_rd : '0;
        case (r_i)
            3'd0:    pat = ent.quartic;
            3'd1:    pat = ent.cubic;
            3'd2:    pat = ent.square;
            3'd3:    pat = {{32{ent.linear[31]}}, ent.linear};
            default: pat = {{32{ent.constant[31]}}, ent.constant};
        endcase
        tm    = pat * $signed({1'b0, ptg_term_mul(r_p, r_i)});
        te    = {{(ACC_W-69){tm[68]}}, tm};
        shamt = 8'(ptg_term_shk(r_i) * FRAC_BITS);
        tsh   = te <<< shamt;
        prod  = r_acc[31:0] * r_in.eval_time + {32'd0, r_carry};
        case (r_p)
            PL_POS:  samt = 8'(5 * FRAC_BITS);
            PL_VEL:  samt = 8'(4 * FRAC_BITS);
            default: samt = 8'(3 * FRAC_BITS);
        endcase
        sh = $signed(r_acc) >>> samt;
        if ((&sh[ACC_W-1:31]) || !(|sh[ACC_W-1:31])) begin
            satv = sh[31:0];
        end else begin
            satv = sh[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.cmd == CMD_PLAN) begin
                        if (i_in.duration == 32'd0 || oor_in) n_state = S_DONE;
                        else                                  n_state = S_DV;
                    end else begin
                        n_state = oor_in ? S_DONE : S_RD;
                    end
                end
            end
            S_DV:     n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_done) n_state = (r_chain == CH_SQUARE) ? S_WRITE : S_DSTART;
            end
            S_WRITE: n_state = S_DONE;
            S_RD:    n_state = S_TERM;
            S_TERM:  n_state = (r_i == 3'(3'd4 - {1'b0, r_p})) ? S_FIN : S_MUL;
            S_MUL:   n_state = (r_limb == 3'(LIMBS - 1)) ? S_TERM : S_MUL;
            S_FIN:   n_state = (r_p == PL_ACC) ? S_DONE : S_TERM;
            S_DONE:  n_state = out_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_state == S_WRITE) begin
            r_vld[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_mem[addr] <= '{quartic: r_q4, cubic: r_q3, square: r_q2,
                             linear: r_in.start_vel, constant: r_in.start_pos};
        end
        r_rd     <= r_mem[addr];
        r_rd_vld <= r_vld[addr] && !oor;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_in   <= i_in;
                    r_err  <= (i_in.cmd == CMD_PLAN) && (i_in.duration == 32'd0);
                    r_res  <= '{default: '0};
                    r_p    <= PL_POS;
                    r_i    <= '0;
                    r_acc  <= '0;
                end
            end
            S_DV: begin
                r_dv    <= r_in.start_vel * $signed({1'b0, r_in.duration});
                r_q4    <= '0;
                r_chain <= (r_in.mode == MODE_QUARTIC) ? CH_QUARTIC : CH_CUBIC;
            end
            S_DWAIT: begin
                if (div_done) begin
                    case (r_chain)
                        CH_QUARTIC: r_q4 <= div_coef;
                        CH_CUBIC:   r_q3 <= div_coef;
                        default:    r_q2 <= div_coef;
                    endcase
                    r_chain <= r_chain + 2'd1;
                end
            end
            S_TERM: begin
                r_acc   <= r_acc + tsh;
                r_i     <= r_i + 3'd1;
                r_limb  <= '0;
                r_carry <= '0;
            end
            S_MUL: begin
                r_acc   <= {prod[31:0], r_acc[ACC_W-1:32]};
                r_carry <= prod[63:32];
                r_limb  <= r_limb + 3'd1;
            end
            S_FIN: begin
                r_res[r_p] <= satv;
                r_p        <= r_p + 2'd1;
                r_i        <= '0;
                r_acc      <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= '{position: r_res[0], velocity: r_res[1], acceleration: r_res[2],
                       zero_duration_error: r_err};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
`default_nettype wire

FILE: verif/testbench.sv
module testbench;
    import ptg_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int N_ITEMS    = 1850;
    localparam int STALL_MAX  = 20000;
    localparam int HOLD_LEN   = 3000;

    class traj_scoreboard;
        logic signed [63:0] c_quart [8];
        logic signed [63:0] c_cub   [8];
        logic signed [63:0] c_sq    [8];
        logic signed [31:0] c_lin   [8];
        logic signed [31:0] c_con   [8];
        t_out               exp_q [$];
        int                 errors;
        int                 n_plan, n_eval, n_zero;

        function new();
            for (int j = 0; j < 8; j++) begin
                c_quart[j] = '0; c_cub[j] = '0; c_sq[j] = '0;
                c_lin[j] = '0; c_con[j] = '0;
            end
            errors = 0; n_plan = 0; n_eval = 0; n_zero = 0;
        endfunction

        // repeated (q << F) / T, with the intermediate clamp at 2^100
        function logic signed [63:0] solve_coef(logic signed [255:0] num, logic [31:0] dur,
                                                int steps);
            logic [255:0] m;
            logic [255:0] dd;
            logic         neg;
            neg = num[255];
            m   = neg ? -num : num;
            dd  = {224'b0, dur};
            for (int i = 0; i < steps; i++) begin
                m = (m << FRAC) / dd;
                if (m >= (256'd1 << 100)) m = 256'd1 << 100;
            end
            if (neg) begin
                if (m > 256'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
                return -m[63:0];
            end
            if (m > 256'h7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
            return m[63:0];
        endfunction

        function logic signed [31:0] horner(int n, logic signed [255:0] pat [5], int mul [5],
                                            int sh [5], logic [31:0] t, int outsh);
            logic signed [255:0] acc;
            logic signed [255:0] tt;
            logic signed [255:0] term;
            acc = '0;
            tt  = {224'b0, t};
            for (int i = 0; i < n; i++) begin
                term = pat[i] * mul[i];
                acc  = acc * tt + (term <<< sh[i]);
            end
            acc = acc >>> outsh;
            if (acc[255:31] != {225{acc[31]}})
                return acc[255] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            return acc[31:0];
        endfunction

        function void note(t_in x);
            t_out                r;
            logic signed [255:0] dv, x0, x1, xa, n4, n3, n2;
            logic signed [255:0] pat [5];
            int                  mp [5];
            int                  mv [5];
            int                  ma [5];
            int                  sp [5];
            int                  sv [5];
            int                  j;
            r = '0;
            j = x.joint;
            if (x.cmd == CMD_PLAN) begin
                n_plan++;
                if (x.duration == 0) begin
                    r.zero_duration_error = 1'b1;
                    n_zero++;
                end else begin
                    x0 = x.start_pos; x1 = x.end_pos; xa = x.via_pos;
                    dv = x.start_vel;
                    dv = dv * $signed({224'b0, x.duration});
                    if (x.mode == MODE_CUBIC) begin
                        n3 = dv + ((2 * x0 - 2 * x1) <<< FRAC);
                        n2 = -2 * dv + ((3 * x1 - 3 * x0) <<< FRAC);
                        c_quart[j] = '0;
                    end else begin
                        n4 = -2 * dv + ((-8 * x0 - 8 * x1 + 16 * xa) <<< FRAC);
                        n3 = 5 * dv + ((18 * x0 + 14 * x1 - 32 * xa) <<< FRAC);
                        n2 = -4 * dv + ((-11 * x0 - 5 * x1 + 16 * xa) <<< FRAC);
                        c_quart[j] = solve_coef(n4, x.duration, 4);
                    end
                    c_cub[j] = solve_coef(n3, x.duration, 3);
                    c_sq[j]  = solve_coef(n2, x.duration, 2);
                    c_lin[j] = x.start_vel;
                    c_con[j] = x.start_pos;
                end
            end else begin
                n_eval++;
                pat[0] = c_quart[j]; pat[1] = c_cub[j]; pat[2] = c_sq[j];
                pat[3] = c_lin[j];   pat[4] = c_con[j];
                mp = '{1, 1, 1, 1, 1};
                mv = '{4, 3, 2, 1, 0};
                ma = '{12, 6, 2, 0, 0};
                sp = '{0, FRAC, 2 * FRAC, 4 * FRAC, 5 * FRAC};
                sv = '{0, FRAC, 2 * FRAC, 4 * FRAC, 0};
                r.position     = horner(5, pat, mp, sp, x.eval_time, 5 * FRAC);
                r.velocity     = horner(4, pat, mv, sv, x.eval_time, 4 * FRAC);
                r.acceleration = horner(3, pat, ma, sv, x.eval_time, 3 * FRAC);
            end
            exp_q.push_back(r);
        endfunction

        function void check(t_out y);
            t_out e;
            if (exp_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (y.position !== e.position) begin
                $error("position exp %0d got %0d", e.position, y.position);
                errors++;
            end
            if (y.velocity !== e.velocity) begin
                $error("velocity exp %0d got %0d", e.velocity, y.velocity);
                errors++;
            end
            if (y.acceleration !== e.acceleration) begin
                $error("acceleration exp %0d got %0d", e.acceleration, y.acceleration);
                errors++;
            end
            if (y.zero_duration_error !== e.zero_duration_error) begin
                $error("zero_duration_error exp %0d got %0d",
                       e.zero_duration_error, y.zero_duration_error);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    polynomial_trajectory_generator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    traj_scoreboard sb = new();

    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    logic hold_req     = 1'b0;
    logic hold_used    = 1'b0;
    int   hold_left    = 0;
    logic in_fire      = 1'b0;
    logic out_fire     = 1'b0;
    t_out out_snap;
    int   quiet_cycles = 0;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // sample at the falling edge: stable values of the upcoming rising edge
    always @(negedge i_clk) begin
        in_fire  = i_in_valid && o_in_ready && i_rst_n;
        out_fire = o_out_valid && i_out_ready && i_rst_n;
        out_snap = o_out;
    end

    always @(posedge i_clk) begin
        if (out_fire) sb.check(out_snap);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_used   <= 1'b1;
            hold_left   <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("watchdog: no transaction for %0d cycles", STALL_MAX);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send(t_in x);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge i_clk);
        end
        i_in       <= x;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_fire);
        sb.note(x);
    endtask

    function automatic logic [31:0] pick_val();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return {{12{1'b0}}, 20'($urandom)};
            2:       return -{{12{1'b0}}, 20'($urandom)};
            default: return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_dur();
        case ($urandom_range(19))
            0:       return 32'd0;
            1, 2:    return $urandom;
            3:       return $urandom_range(255);
            default: return $urandom_range(32'h0008_0000, 32'h0004_0000 * 5);
        endcase
    endfunction

    task automatic plan(logic [2:0] j, logic md, logic [31:0] p0, logic [31:0] v0,
                        logic [31:0] p1, logic [31:0] pa, logic [31:0] dur);
        t_in x;
        x = '0;
        x.cmd = CMD_PLAN; x.joint = j; x.mode = md;
        x.start_pos = p0; x.start_vel = v0; x.end_pos = p1; x.via_pos = pa;
        x.duration = dur; x.eval_time = $urandom;
        send(x);
    endtask

    task automatic evaluate(logic [2:0] j, logic [31:0] t);
        t_in x;
        x = '0;
        x.cmd = CMD_EVAL; x.joint = j; x.eval_time = t;
        x.mode = 1'($urandom); x.start_pos = $urandom; x.start_vel = $urandom;
        x.end_pos = $urandom; x.via_pos = $urandom; x.duration = $urandom;
        send(x);
    endtask

    task automatic random_item();
        t_in  x;
        logic [31:0] dur;
        x = '0;
        if ($urandom_range(99) < 20) begin
            dur = pick_dur();
            plan(3'($urandom), 1'($urandom), pick_val(), pick_val(), pick_val(),
                 pick_val(), dur);
        end else begin
            dur = sb.n_plan[0] ? $urandom_range(32'h0010_0000) : $urandom;
            if ($urandom_range(9) == 0) dur = $urandom;
            evaluate(3'($urandom), dur);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        evaluate(3'd5, 32'h0001_0000);
        plan(3'd0, MODE_CUBIC, 32'h0001_0000, 32'h0, 32'h0005_0000, 32'h0, 32'h0002_0000);
        evaluate(3'd0, 32'h0);
        evaluate(3'd0, 32'h0001_0000);
        evaluate(3'd0, 32'h0002_0000);
        plan(3'd7, MODE_QUARTIC, 32'hFFFF_0000, 32'h0000_8000, 32'h0003_0000,
             32'h0004_0000, 32'h0001_8000);
        evaluate(3'd7, 32'h0000_C000);
        evaluate(3'd7, 32'hFFFF_FFFF);
        plan(3'd7, MODE_CUBIC, 32'h1234_5678, 32'h1, 32'h2, 32'h3, 32'h0);
        evaluate(3'd7, 32'h0001_8000);
        plan(3'd1, MODE_QUARTIC, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'd1);
        evaluate(3'd1, 32'd1);
        evaluate(3'd1, 32'hFFFF_FFFF);
        plan(3'd2, MODE_QUARTIC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'hFFFF_FFFF);
        evaluate(3'd2, 32'h8000_0000);
        plan(3'd3, MODE_CUBIC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h0, 32'h0000_0100);
        evaluate(3'd3, 32'h0000_0080);
        plan(3'd4, MODE_QUARTIC, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        evaluate(3'd4, 32'h0);
        plan(3'd6, MODE_QUARTIC, 32'h0002_0000, 32'hFFFF_0000, 32'h0002_0000,
             32'h0002_0000, 32'h0003_0000);
        evaluate(3'd6, 32'h0003_0000);

        snd_idle_pct = 25; rcv_idle_pct = 86;
        for (int i = 0; i < (N_ITEMS - 21) / 3; i++) random_item();
        snd_idle_pct = 86; rcv_idle_pct = 25;
        for (int i = 0; i < (N_ITEMS - 21) / 3; i++) random_item();
        snd_idle_pct = 0; rcv_idle_pct = 0;
        hold_req <= 1'b1;
        for (int i = 0; i < (N_ITEMS - 21) / 3; i++) random_item();
        i_in_valid <= 1'b0;

        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d plan transactions (%0d with zero duration), %0d evaluations",
                 sb.n_plan, sb.n_zero, sb.n_eval);
        $display("idle mixes on both sides plus one long output back-pressure stretch");
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
